// ----- hdl/rbo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rbo_pkg;

    // The doubled box offset 2*origin - 2*corner - span needs three bits more
    // than a coordinate to stay exact.
    localparam int unsigned OFFSET_GROWTH = 3;

    // The difference of two exact products gains one bit over a product.
    localparam int unsigned CROSS_GROWTH = 1;

endpackage

`default_nettype wire

// ----- hdl/rbo_cross_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One cross-product axis of the separating-axis test. The first stage
// registers the two signed products of direction and offset and the two
// unsigned products of span and absolute direction. The second stage forms
// |dir_a*off_b - dir_b*off_a| and compares it with span_a*|dir_b| +
// span_b*|dir_a|. All widths are exact, so nothing wraps.
module rbo_cross_unit #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  wire                                                  clk,
    input  wire                                                  load,
    input  wire  signed [COORD_WIDTH-1:0]                        dir_a,
    input  wire  signed [COORD_WIDTH-1:0]                        dir_b,
    input  wire  signed [COORD_WIDTH+rbo_pkg::OFFSET_GROWTH-1:0] off_a,
    input  wire  signed [COORD_WIDTH+rbo_pkg::OFFSET_GROWTH-1:0] off_b,
    input  wire         [COORD_WIDTH-2:0]                        span_a,
    input  wire         [COORD_WIDTH-2:0]                        span_b,
    input  wire         [COORD_WIDTH-1:0]                        adir_a,
    input  wire         [COORD_WIDTH-1:0]                        adir_b,
    output logic                                                 separated
);
    import rbo_pkg::*;

    localparam int unsigned OffW   = COORD_WIDTH + OFFSET_GROWTH;
    localparam int unsigned ProdW  = COORD_WIDTH + OffW;
    localparam int unsigned CrossW = ProdW + CROSS_GROWTH;
    localparam int unsigned LimPW  = 2 * COORD_WIDTH - 1;
    localparam int unsigned LimW   = LimPW + 1;

    logic signed [ProdW-1:0]  prod_a_reg;
    logic signed [ProdW-1:0]  prod_b_reg;
    logic        [LimPW-1:0]  lim_a_reg;
    logic        [LimPW-1:0]  lim_b_reg;

    logic signed [CrossW-1:0] cross_diff;
    logic        [CrossW-1:0] cross_mag;
    logic        [LimW-1:0]   limit_sum;

    // Product stage: four multipliers, each registered.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_a_reg <= ProdW'(dir_a) * ProdW'(off_b);
            prod_b_reg <= ProdW'(dir_b) * ProdW'(off_a);
            lim_a_reg  <= LimPW'(span_a) * LimPW'(adir_b);
            lim_b_reg  <= LimPW'(span_b) * LimPW'(adir_a);
        end
    end

    // Compare stage: magnitude of the cross component against the projected
    // extents.
    always_comb
    begin
        cross_diff = CrossW'(prod_a_reg) - CrossW'(prod_b_reg);
        cross_mag  = cross_diff[CrossW-1] ? CrossW'(-cross_diff) : CrossW'(cross_diff);
        limit_sum  = LimW'(lim_a_reg) + LimW'(lim_b_reg);
        separated  = cross_mag > CrossW'(limit_sum);
    end

endmodule

`default_nettype wire

// ----- hdl/ray_box_overlap_test_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                      Payload
// query     query_valid / query_ready      origin_*, heading_*, corner_*, span_*
// result    result_valid / result_ready    hit
//
// A three-stage pipeline: offset register, product register, result register.
// One query is taken every cycle unless a low result_ready stalls the pipeline.
// rst_n clears the stage valid flags only; data registers carry no reset.
// Each stage loads when it is empty or its content moves on, so bubbles close
// up and a new query is taken while a finished result still waits.
module ray_box_overlap_test_top #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          query_valid,
    output logic                         query_ready,
    input  wire  signed [COORD_WIDTH-1:0] origin_x,
    input  wire  signed [COORD_WIDTH-1:0] origin_y,
    input  wire  signed [COORD_WIDTH-1:0] origin_z,
    input  wire  signed [COORD_WIDTH-1:0] heading_x,
    input  wire  signed [COORD_WIDTH-1:0] heading_y,
    input  wire  signed [COORD_WIDTH-1:0] heading_z,
    input  wire  signed [COORD_WIDTH-1:0] corner_x,
    input  wire  signed [COORD_WIDTH-1:0] corner_y,
    input  wire  signed [COORD_WIDTH-1:0] corner_z,
    input  wire         [COORD_WIDTH-2:0] span_x,
    input  wire         [COORD_WIDTH-2:0] span_y,
    input  wire         [COORD_WIDTH-2:0] span_z,
    output logic                         result_valid,
    input  wire                          result_ready,
    output logic                         hit
);
    import rbo_pkg::*;

    localparam int unsigned OffW = COORD_WIDTH + OFFSET_GROWTH;

    logic signed [COORD_WIDTH-1:0] origin_in [3];
    logic signed [COORD_WIDTH-1:0] heading_in [3];
    logic signed [COORD_WIDTH-1:0] corner_in [3];
    logic        [COORD_WIDTH-2:0] span_in [3];
    logic signed [OffW-1:0]        off_next [3];
    logic        [COORD_WIDTH-1:0] adir_next [3];

    logic signed [OffW-1:0]        off_reg [3];
    logic signed [COORD_WIDTH-1:0] dir_reg [3];
    logic        [COORD_WIDTH-1:0] adir_reg [3];
    logic        [COORD_WIDTH-2:0] span_reg [3];

    logic        [OffW-1:0]        off_mag [3];
    logic        [2:0]             slab_sep;
    logic                          slab_sep_reg;
    logic        [2:0]             cross_sep;

    logic stage1_valid_reg;
    logic stage2_valid_reg;
    logic result_valid_reg;
    logic hit_reg;

    logic accept;
    logic load2;
    logic load3;

    // Gather the per-axis ports into lanes.
    always_comb
    begin
        origin_in[0]  = origin_x;
        origin_in[1]  = origin_y;
        origin_in[2]  = origin_z;
        heading_in[0] = heading_x;
        heading_in[1] = heading_y;
        heading_in[2] = heading_z;
        corner_in[0]  = corner_x;
        corner_in[1]  = corner_y;
        corner_in[2]  = corner_z;
        span_in[0]    = span_x;
        span_in[1]    = span_y;
        span_in[2]    = span_z;
    end

    // Pipeline flow: each stage loads when empty or when it empties this cycle.
    always_comb
    begin
        load3       = stage2_valid_reg && (!result_valid_reg || result_ready);
        load2       = stage1_valid_reg && (!stage2_valid_reg || load3);
        query_ready = !stage1_valid_reg || load2;
        accept      = query_valid && query_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                stage1_valid_reg <= 1'b1;
            else if (load2)
                stage1_valid_reg <= 1'b0;

            if (load2)
                stage2_valid_reg <= 1'b1;
            else if (load3)
                stage2_valid_reg <= 1'b0;

            if (load3)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Offset stage: doubled offset from the box centre and absolute direction.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            off_next[k]  = {{2{origin_in[k][COORD_WIDTH-1]}}, origin_in[k], 1'b0}
                         - {{2{corner_in[k][COORD_WIDTH-1]}}, corner_in[k], 1'b0}
                         - OffW'(span_in[k]);
            adir_next[k] = heading_in[k][COORD_WIDTH-1] ? COORD_WIDTH'(-heading_in[k])
                                                        : COORD_WIDTH'(heading_in[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                off_reg[k]  <= off_next[k];
                dir_reg[k]  <= heading_in[k];
                adir_reg[k] <= adir_next[k];
                span_reg[k] <= span_in[k];
            end
        end
    end

    // Slab test: origin outside the slab and not heading back towards it.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            off_mag[k]  = off_reg[k][OffW-1] ? OffW'(-off_reg[k]) : OffW'(off_reg[k]);
            slab_sep[k] = (off_mag[k] > OffW'(span_reg[k]))
                       && !((off_reg[k] != '0) && (dir_reg[k] != '0)
                            && (off_reg[k][OffW-1] != dir_reg[k][COORD_WIDTH-1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
            slab_sep_reg <= |slab_sep;
    end

    // Cross-product axes, one unit each; the products register on load2.
    rbo_cross_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross_x (
        .clk       (clk),
        .load      (load2),
        .dir_a     (dir_reg[1]),
        .dir_b     (dir_reg[2]),
        .off_a     (off_reg[1]),
        .off_b     (off_reg[2]),
        .span_a    (span_reg[1]),
        .span_b    (span_reg[2]),
        .adir_a    (adir_reg[1]),
        .adir_b    (adir_reg[2]),
        .separated (cross_sep[0])
    );

    rbo_cross_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross_y (
        .clk       (clk),
        .load      (load2),
        .dir_a     (dir_reg[2]),
        .dir_b     (dir_reg[0]),
        .off_a     (off_reg[2]),
        .off_b     (off_reg[0]),
        .span_a    (span_reg[2]),
        .span_b    (span_reg[0]),
        .adir_a    (adir_reg[2]),
        .adir_b    (adir_reg[0]),
        .separated (cross_sep[1])
    );

    rbo_cross_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross_z (
        .clk       (clk),
        .load      (load2),
        .dir_a     (dir_reg[0]),
        .dir_b     (dir_reg[1]),
        .off_a     (off_reg[0]),
        .off_b     (off_reg[1]),
        .span_a    (span_reg[0]),
        .span_b    (span_reg[1]),
        .adir_a    (adir_reg[0]),
        .adir_b    (adir_reg[1]),
        .separated (cross_sep[2])
    );

    // Result register: a hit only if no axis separates ray and box.
    always_ff @(posedge clk)
    begin
        if (load3)
            hit_reg <= !slab_sep_reg && !(|cross_sep);
    end

    assign result_valid = result_valid_reg;
    assign hit          = hit_reg;

endmodule

`default_nettype wire
